FILE: rtl/quad_cascaded_pid_mixer_assert.svh
// Assertion macros shared by the checker.
`ifndef QUAD_CASCADED_PID_MIXER_ASSERT_SVH
`define QUAD_CASCADED_PID_MIXER_ASSERT_SVH
`define QCPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QCPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/qcpm_pkg.sv
package qcpm_pkg;
    localparam int unsigned PWM_LOW_DEF  = 1000;
    localparam int unsigned PWM_HIGH_DEF = 2000;
    localparam logic signed [31:0] ANG15_Q16      = 32'sd17157;
    localparam logic signed [31:0] HALF_SQRT2_Q16 = 32'sd46341;
    localparam logic signed [31:0] ONE_Q16        = 32'sd65536;
    localparam int unsigned NUM_REGS = 8;

    typedef enum logic [2:0] {
        REG_TILT_ANG   = 3'd0,
        REG_HEAD_ANG   = 3'd1,
        REG_TILT_P     = 3'd2,
        REG_TILT_I     = 3'd3,
        REG_TILT_D     = 3'd4,
        REG_HEAD_P     = 3'd5,
        REG_HEAD_I     = 3'd6,
        REG_HEAD_D     = 3'd7
    } reg_idx_t;

    localparam logic [31:0] REG_RESET [NUM_REGS] = '{
        32'd251658240, 32'd218103808, 32'd335544, 32'd6711,
        32'd167772, 32'd167772, 32'd10066, 32'd268435
    };

    typedef struct packed {
        logic        start;
        logic        gain_mode;
        logic [31:0] a;
        logic [32:0] b;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(34'(a) - 34'(b));
    endfunction
endpackage

FILE: rtl/quad_cascaded_pid_mixer.sv
// Path: a disarmed beat goes from acceptance through start_reg, S_DONE and finish
// to the output register; an armed beat first issues 20 products one at a time
// through one shared multiplier.
// Throughput: one beat at a time; s_ready returns once the result beat is taken.
// Reset: synchronous active-low aresetn restores the gain registers, clears the
// integrals, previous errors and heading offset, and empties the output register.
module quad_cascaded_pid_mixer #(
    parameter int unsigned PWM_LOW  = qcpm_pkg::PWM_LOW_DEF,
    parameter int unsigned PWM_HIGH = qcpm_pkg::PWM_HIGH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [14:0]        s_throttle_cmd,
    input  logic signed [15:0] s_pitch_cmd,
    input  logic signed [15:0] s_roll_cmd,
    input  logic signed [15:0] s_yaw_cmd,
    input  logic               s_arm_switch,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_roll_angle,
    input  logic signed [15:0] s_heading_angle,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    input  logic signed [15:0] s_gyro_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_motor_pwm_0,
    output logic [15:0]        m_motor_pwm_1,
    output logic [15:0]        m_motor_pwm_2,
    output logic [15:0]        m_motor_pwm_3,
    output logic               m_armed_flag
);
    logic [31:0] gain_reg [qcpm_pkg::NUM_REGS];
    logic busy_reg, out_valid_reg, finish, armed, mdone, yaw_unused;
    logic [15:0] pwm [4];
    logic signed [31:0] mres;
    qcpm_pkg::mul_req_t mreq;
    logic signed [15:0] cmd_h [2], ang_h [3], gy_h [3];
    logic [14:0] thr_hold;
    logic arm_hold;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg && !out_valid_reg;
    assign m_valid   = out_valid_reg;
    assign yaw_unused = ^s_yaw_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < qcpm_pkg::NUM_REGS; i++) gain_reg[i] <= qcpm_pkg::REG_RESET[i];
        end else begin
            if (cfg_valid) gain_reg[cfg_index] <= cfg_data;
            if (s_valid && s_ready) busy_reg <= 1'b1;
            if (finish) begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                m_motor_pwm_0 <= pwm[0];
                m_motor_pwm_1 <= pwm[1];
                m_motor_pwm_2 <= pwm[2];
                m_motor_pwm_3 <= pwm[3];
                m_armed_flag  <= armed;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            thr_hold <= s_throttle_cmd;
            cmd_h[0] <= s_pitch_cmd;
            cmd_h[1] <= s_roll_cmd;
            arm_hold <= s_arm_switch ^ (yaw_unused & 1'b0);
            ang_h[0] <= s_pitch_angle;
            ang_h[1] <= s_roll_angle;
            ang_h[2] <= s_heading_angle;
            gy_h[0]  <= s_gyro_x;
            gy_h[1]  <= s_gyro_y;
            gy_h[2]  <= s_gyro_z;
        end
    end

    logic start_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) start_reg <= 1'b0;
        else start_reg <= s_valid && s_ready;
    end

    qcpm_seq #(.PWM_LOW(PWM_LOW), .PWM_HIGH(PWM_HIGH)) u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .thr_in(thr_hold), .pcmd_in(cmd_h[0]), .rcmd_in(cmd_h[1]), .arm_in(arm_hold),
        .pang_in(ang_h[0]), .rang_in(ang_h[1]), .head_in(ang_h[2]),
        .gx_in(gy_h[0]), .gy_in(gy_h[1]), .gz_in(gy_h[2]), .gains(gain_reg),
        .finish(finish), .pwm(pwm), .armed(armed),
        .mreq(mreq), .mres(mres), .mdone(mdone)
    );

    qcpm_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .req(mreq), .result(mres), .done(mdone)
    );
endmodule

FILE: rtl/qcpm_mul.sv
module qcpm_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  qcpm_pkg::mul_req_t  req,
    output logic signed [31:0]  result,
    output logic                done
);
    logic signed [65:0] prod_reg;
    logic               mode_reg;
    logic               busy_reg;
    logic signed [65:0] rounded;
    logic signed [65:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            busy_reg <= req.start;
            done     <= busy_reg;
        end
        if (req.start) begin
            prod_reg <= $signed({{34{req.a[31]}}, req.a}) * $signed({{33{req.b[32]}}, req.b});
            mode_reg <= req.gain_mode;
        end
        if (busy_reg) begin
            result <= qcpm_pkg::sat32(shifted > 66'sh0_FFFF_FFFF ? 34'sh0_FFFF_FFFF :
                      shifted < -66'sh1_0000_0000 ? -34'sh1_0000_0000 : shifted[33:0]);
        end
    end

    always_comb begin
        rounded = prod_reg + (mode_reg ? 66'sd8388608 : 66'sd32768);
        shifted = mode_reg ? (rounded >>> 24) : (rounded >>> 16);
    end
endmodule

FILE: rtl/qcpm_seq.sv
module qcpm_seq #(
    parameter int unsigned PWM_LOW  = qcpm_pkg::PWM_LOW_DEF,
    parameter int unsigned PWM_HIGH = qcpm_pkg::PWM_HIGH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [14:0]         thr_in,
    input  logic signed [15:0]  pcmd_in,
    input  logic signed [15:0]  rcmd_in,
    input  logic                arm_in,
    input  logic signed [15:0]  pang_in,
    input  logic signed [15:0]  rang_in,
    input  logic signed [15:0]  head_in,
    input  logic signed [15:0]  gx_in,
    input  logic signed [15:0]  gy_in,
    input  logic signed [15:0]  gz_in,
    input  logic [31:0]         gains [qcpm_pkg::NUM_REGS],
    output logic                finish,
    output logic [15:0]         pwm [4],
    output logic                armed,
    output qcpm_pkg::mul_req_t  mreq,
    input  logic signed [31:0]  mres,
    input  logic                mdone
);
    localparam logic [32:0] SPAN = 33'(PWM_HIGH - PWM_LOW);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_MIX, S_PWM, S_DONE} state_t;
    typedef enum logic [4:0] {
        OP_PCMD, OP_RCMD, OP_SPP, OP_SPR, OP_SPY,
        OP_IP, OP_PP, OP_DP, OP_IR, OP_PR, OP_DR, OP_IY, OP_PY, OP_DY,
        OP_PT, OP_RT, OP_M0, OP_M1, OP_M2, OP_M3
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic signed [31:0] integ_reg [3];
    logic signed [31:0] prev_reg [3];
    logic signed [15:0] hoff_reg;
    logic signed [31:0] t_reg [3];
    logic signed [31:0] e_reg [3];
    logic signed [31:0] out_reg [3];
    logic signed [31:0] pt_reg, rt_reg;
    logic signed [31:0] mot_reg [4];
    logic signed [31:0] thr, lim, a_sel;
    logic [32:0] b_sel;
    logic gm_sel;
    logic signed [31:0] ax_e, clamped, ai, mclamp;
    logic [1:0] ax;
    logic signed [16:0] yo;

    always_comb begin
        thr = {15'd0, thr_in, 2'b00};
        lim = {14'd0, thr_in, 3'b000};
        yo  = 17'(head_in) + 17'(hoff_reg);
        a_sel = '0; b_sel = '0; gm_sel = 1'b1; ax = 2'd0;
        unique case (op_reg)
            OP_PCMD: begin a_sel = 32'(pcmd_in) <<< 2; b_sel = 33'(qcpm_pkg::ANG15_Q16);
                gm_sel = 1'b0; end
            OP_RCMD: begin a_sel = 32'(rcmd_in) <<< 2; b_sel = 33'(qcpm_pkg::ANG15_Q16);
                gm_sel = 1'b0; end
            OP_SPP: begin a_sel = t_reg[0]; b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_ANG]}; end
            OP_SPR: begin a_sel = t_reg[1]; b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_ANG]}; end
            OP_SPY: begin a_sel = t_reg[2]; b_sel = {1'b0, gains[qcpm_pkg::REG_HEAD_ANG]}; end
            OP_IP: begin a_sel = e_reg[0]; b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_I]}; end
            OP_PP: begin a_sel = e_reg[0]; b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_P]}; end
            OP_DP: begin a_sel = qcpm_pkg::sub_s(e_reg[0], prev_reg[0]);
                b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_D]}; end
            OP_IR: begin a_sel = e_reg[1]; b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_I]};
                ax = 2'd1; end
            OP_PR: begin a_sel = e_reg[1]; b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_P]};
                ax = 2'd1; end
            OP_DR: begin a_sel = qcpm_pkg::sub_s(e_reg[1], prev_reg[1]);
                b_sel = {1'b0, gains[qcpm_pkg::REG_TILT_D]}; ax = 2'd1; end
            OP_IY: begin a_sel = e_reg[2]; b_sel = {1'b0, gains[qcpm_pkg::REG_HEAD_I]};
                ax = 2'd2; end
            OP_PY: begin a_sel = e_reg[2]; b_sel = {1'b0, gains[qcpm_pkg::REG_HEAD_P]};
                ax = 2'd2; end
            OP_DY: begin a_sel = qcpm_pkg::sub_s(e_reg[2], prev_reg[2]);
                b_sel = {1'b0, gains[qcpm_pkg::REG_HEAD_D]}; ax = 2'd2; end
            OP_PT: begin a_sel = out_reg[0]; b_sel = 33'(qcpm_pkg::HALF_SQRT2_Q16);
                gm_sel = 1'b0; end
            OP_RT: begin a_sel = out_reg[1]; b_sel = 33'(qcpm_pkg::HALF_SQRT2_Q16);
                gm_sel = 1'b0; end
            OP_M0: begin a_sel = mclamp; b_sel = SPAN; gm_sel = 1'b0; end
            OP_M1: begin a_sel = mclamp; b_sel = SPAN; gm_sel = 1'b0; ax = 2'd1; end
            OP_M2: begin a_sel = mclamp; b_sel = SPAN; gm_sel = 1'b0; ax = 2'd2; end
            OP_M3: begin a_sel = mclamp; b_sel = SPAN; gm_sel = 1'b0; ax = 2'd3; end
            default: ;
        endcase
        ax_e = e_reg[ax];
        ai = qcpm_pkg::add_s(integ_reg[ax], mres);
        clamped = (ai > lim) ? lim : ((ai < -lim) ? -lim : ai);
        mclamp = mot_reg[ax] < 0 ? 32'sd0 :
                 (mot_reg[ax] > qcpm_pkg::ONE_Q16 ? qcpm_pkg::ONE_Q16 : mot_reg[ax]);
        mreq.start = (state_reg == S_ISSUE);
        mreq.gain_mode = gm_sel;
        mreq.a = a_sel;
        mreq.b = b_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PCMD;
            finish    <= 1'b0;
            armed     <= 1'b0;
            hoff_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end else begin
            finish <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        if (!arm_in) begin
                            hoff_reg <= (head_in == -16'sd32768) ? 16'sd32767 : -head_in;
                            for (int i = 0; i < 3; i++) begin
                                integ_reg[i] <= '0;
                                prev_reg[i]  <= '0;
                            end
                            for (int k = 0; k < 4; k++) pwm[k] <= 16'(PWM_LOW);
                            armed     <= 1'b0;
                            state_reg <= S_DONE;
                        end else begin
                            t_reg[2]  <= -(32'(yo) <<< 4);
                            op_reg    <= OP_PCMD;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (mdone) begin
                        state_reg <= S_ISSUE;
                        op_reg    <= op_t'(op_reg + 5'd1);
                        unique case (op_reg) inside
                            OP_PCMD: t_reg[0] <= qcpm_pkg::sub_s(mres, 32'(pang_in) <<< 4);
                            OP_RCMD: t_reg[1] <= qcpm_pkg::sub_s(mres, 32'(rang_in) <<< 4);
                            OP_SPP: e_reg[0] <= qcpm_pkg::sub_s(mres, 32'(gy_in) <<< 6);
                            OP_SPR: e_reg[1] <= qcpm_pkg::sub_s(mres, 32'(gx_in) <<< 6);
                            OP_SPY: e_reg[2] <= qcpm_pkg::sub_s(mres, 32'(gz_in) <<< 6);
                            OP_IP, OP_IR, OP_IY: integ_reg[ax] <= clamped;
                            OP_PP, OP_PR, OP_PY: out_reg[ax] <= qcpm_pkg::add_s(mres,
                                                                                integ_reg[ax]);
                            OP_DP, OP_DR, OP_DY: begin
                                out_reg[ax] <= qcpm_pkg::add_s(out_reg[ax], mres);
                                prev_reg[ax] <= ax_e;
                            end
                            OP_PT: pt_reg <= mres;
                            OP_RT: begin
                                rt_reg <= mres;
                                state_reg <= S_MIX;
                            end
                            OP_M0, OP_M1, OP_M2: pwm[ax] <= 16'(PWM_LOW) + mres[15:0];
                            OP_M3: begin
                                pwm[3] <= 16'(PWM_LOW) + mres[15:0];
                                armed <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MIX: begin
                    mot_reg[0] <= qcpm_pkg::add_s(qcpm_pkg::sub_s(qcpm_pkg::add_s(thr, pt_reg),
                                  rt_reg), out_reg[2]);
                    mot_reg[1] <= qcpm_pkg::sub_s(qcpm_pkg::add_s(qcpm_pkg::add_s(thr, pt_reg),
                                  rt_reg), out_reg[2]);
                    mot_reg[2] <= qcpm_pkg::add_s(qcpm_pkg::add_s(qcpm_pkg::sub_s(thr, pt_reg),
                                  rt_reg), out_reg[2]);
                    mot_reg[3] <= qcpm_pkg::sub_s(qcpm_pkg::sub_s(qcpm_pkg::sub_s(thr, pt_reg),
                                  rt_reg), out_reg[2]);
                    op_reg    <= OP_M0;
                    state_reg <= S_ISSUE;
                end
                S_DONE: begin
                    finish    <= 1'b1;
                    state_reg <= S_PWM;
                end
                S_PWM: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/qcpm_checker.sv
`include "quad_cascaded_pid_mixer_assert.svh"
module qcpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_motor_pwm_0,
    input logic        m_armed_flag
);
    `QCPM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `QCPM_ASSERT_IMPL(a_no_accept_while_out, aclk, aresetn, m_valid, !s_ready)
    `QCPM_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_motor_pwm_0))
    `QCPM_ASSERT_IMPL(a_disarmed_min, aclk, aresetn, m_valid && !m_armed_flag,
                      m_motor_pwm_0 == 16'(qcpm_pkg::PWM_LOW_DEF))
endmodule

bind quad_cascaded_pid_mixer qcpm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_motor_pwm_0(m_motor_pwm_0),
    .m_armed_flag(m_armed_flag)
);

FILE: dv/testbench.sv
module testbench;
    typedef struct packed {
        logic [14:0]        thr;
        logic signed [15:0] pcmd;
        logic signed [15:0] rcmd;
        logic signed [15:0] ycmd;
        logic               arm;
        logic signed [15:0] pang;
        logic signed [15:0] rang;
        logic signed [15:0] hang;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } tick_t;

    typedef struct packed {
        logic [15:0] pwm0;
        logic [15:0] pwm1;
        logic [15:0] pwm2;
        logic [15:0] pwm3;
        logic        armed;
    } motors_t;

    typedef struct packed {
        tick_t   tick;
        logic    typed;
        motors_t motors;
    } row_t;

    localparam int N_DIRECTED = 14;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    qcpm_pkg::reg_idx_t   cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    tick_t                s_tick;
    logic                 m_valid;
    logic                 m_ready;
    motors_t              m_motors;

    motors_t     motor_q[$];
    logic [31:0] gain[qcpm_pkg::NUM_REGS];
    int          integ[3];
    int          prev_err[3];
    int          head_off;
    int          errors;
    bit          quiet;
    bit          hold_req;
    row_t        directed[N_DIRECTED];

    quad_cascaded_pid_mixer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_throttle_cmd(s_tick.thr), .s_pitch_cmd(s_tick.pcmd),
        .s_roll_cmd(s_tick.rcmd), .s_yaw_cmd(s_tick.ycmd),
        .s_arm_switch(s_tick.arm), .s_pitch_angle(s_tick.pang),
        .s_roll_angle(s_tick.rang), .s_heading_angle(s_tick.hang),
        .s_gyro_x(s_tick.gx), .s_gyro_y(s_tick.gy), .s_gyro_z(s_tick.gz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_motor_pwm_0(m_motors.pwm0), .m_motor_pwm_1(m_motors.pwm1),
        .m_motor_pwm_2(m_motors.pwm2), .m_motor_pwm_3(m_motors.pwm3),
        .m_armed_flag(m_motors.armed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("quad_cascaded_pid_mixer test failed");
        $finish;
    end

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int qmul(int a, int b);
        return clip32((longint'(a) * longint'(b) + 64'sd32768) >>> 16);
    endfunction

    function automatic int gmul(int a, logic [31:0] g);
        return clip32((longint'(a) * longint'({32'd0, g}) + 64'sd8388608) >>> 24);
    endfunction

    function automatic int pid_axis(int ax, int e, logic [31:0] kp, logic [31:0] ki,
                                    logic [31:0] kd, int lim);
        int acc;
        int y;
        acc = clip32(longint'(integ[ax]) + gmul(e, ki));
        if (acc > lim) begin
            acc = lim;
        end
        if (acc < -lim) begin
            acc = -lim;
        end
        integ[ax] = acc;
        y = clip32(longint'(gmul(e, kp)) + acc);
        y = clip32(longint'(y) + gmul(clip32(longint'(e) - prev_err[ax]), kd));
        prev_err[ax] = e;
        return y;
    endfunction

    function automatic logic [15:0] pwm_of(int m);
        longint v;
        if (m < 0) begin
            m = 0;
        end
        if (m > qcpm_pkg::ONE_Q16) begin
            m = qcpm_pkg::ONE_Q16;
        end
        v = qcpm_pkg::PWM_LOW_DEF + ((longint'(m) *
            (qcpm_pkg::PWM_HIGH_DEF - qcpm_pkg::PWM_LOW_DEF) + 32768) >>> 16);
        return v[15:0];
    endfunction

    function automatic motors_t mix_tick(tick_t t);
        motors_t r;
        int thr, lim, ep, er, ey, cp, cr, cy, pt, rt;
        if (!t.arm) begin
            head_off = -int'(t.hang);
            if (head_off > 32767) begin
                head_off = 32767;
            end
            for (int i = 0; i < 3; i++) begin
                integ[i] = 0;
                prev_err[i] = 0;
            end
            r.pwm0 = pwm_of(0);
            r.pwm1 = pwm_of(0);
            r.pwm2 = pwm_of(0);
            r.pwm3 = pwm_of(0);
            r.armed = 1'b0;
            return r;
        end
        thr = int'({17'd0, t.thr}) * 4;
        lim = thr * 2;
        ep = clip32(longint'(qmul(int'(t.pcmd) * 4, qcpm_pkg::ANG15_Q16)) - int'(t.pang) * 16);
        er = clip32(longint'(qmul(int'(t.rcmd) * 4, qcpm_pkg::ANG15_Q16)) - int'(t.rang) * 16);
        ey = -((int'(t.hang) + head_off) * 16);
        cp = pid_axis(0, clip32(longint'(gmul(ep, gain[qcpm_pkg::REG_TILT_ANG]))
                                - int'(t.gy) * 64),
                      gain[qcpm_pkg::REG_TILT_P], gain[qcpm_pkg::REG_TILT_I],
                      gain[qcpm_pkg::REG_TILT_D], lim);
        cr = pid_axis(1, clip32(longint'(gmul(er, gain[qcpm_pkg::REG_TILT_ANG]))
                                - int'(t.gx) * 64),
                      gain[qcpm_pkg::REG_TILT_P], gain[qcpm_pkg::REG_TILT_I],
                      gain[qcpm_pkg::REG_TILT_D], lim);
        cy = pid_axis(2, clip32(longint'(gmul(ey, gain[qcpm_pkg::REG_HEAD_ANG]))
                                - int'(t.gz) * 64),
                      gain[qcpm_pkg::REG_HEAD_P], gain[qcpm_pkg::REG_HEAD_I],
                      gain[qcpm_pkg::REG_HEAD_D], lim);
        pt = qmul(cp, qcpm_pkg::HALF_SQRT2_Q16);
        rt = qmul(cr, qcpm_pkg::HALF_SQRT2_Q16);
        r.pwm0 = pwm_of(clip32(longint'(clip32(longint'(clip32(longint'(thr) + pt)) - rt)) + cy));
        r.pwm1 = pwm_of(clip32(longint'(clip32(longint'(clip32(longint'(thr) + pt)) + rt)) - cy));
        r.pwm2 = pwm_of(clip32(longint'(clip32(longint'(clip32(longint'(thr) - pt)) + rt)) + cy));
        r.pwm3 = pwm_of(clip32(longint'(clip32(longint'(clip32(longint'(thr) - pt)) - rt)) - cy));
        r.armed = 1'b1;
        return r;
    endfunction

    function automatic logic signed [15:0] rnd_s16(int span);
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom);
        end
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic tick_t rnd_tick(bit armed);
        tick_t t;
        t.thr  = ($urandom_range(0, 19) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
        t.pcmd = rnd_s16(16384);
        t.rcmd = rnd_s16(16384);
        t.ycmd = 16'($urandom);
        t.arm  = armed;
        t.pang = rnd_s16(2000);
        t.rang = rnd_s16(2000);
        t.hang = rnd_s16(16384);
        t.gx   = rnd_s16(3000);
        t.gy   = rnd_s16(3000);
        t.gz   = rnd_s16(3000);
        return t;
    endfunction

    task automatic send_tick(tick_t t, bit typed, motors_t want);
        motors_t got;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_tick  <= t;
        do @(posedge aclk); while (!s_ready);
        got = mix_tick(t);
        motor_q.push_back(typed ? want : got);
    endtask

    task automatic write_gain(qcpm_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        gain[idx] = val;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (motor_q.size() == 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic cmp(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            errors++;
        end
    endtask

    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        motors_t want;
        if (aresetn && m_valid && m_ready) begin
            if (motor_q.size() == 0) begin
                $display("%0t: result beat with none expected, actual %h", $realtime, m_motors);
                errors++;
            end else begin
                want = motor_q.pop_front();
                cmp("motor_pwm_0", want.pwm0, m_motors.pwm0);
                cmp("motor_pwm_1", want.pwm1, m_motors.pwm1);
                cmp("motor_pwm_2", want.pwm2, m_motors.pwm2);
                cmp("motor_pwm_3", want.pwm3, m_motors.pwm3);
                cmp("armed_flag", 16'(want.armed), 16'(m_motors.armed));
            end
        end
    end

    initial begin
        bit armed;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = qcpm_pkg::REG_TILT_ANG;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_tick    = '0;
        m_ready   = 1'b0;
        errors    = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        head_off  = 0;
        for (int i = 0; i < qcpm_pkg::NUM_REGS; i++) begin
            gain[i] = qcpm_pkg::REG_RESET[i];
        end
        for (int i = 0; i < 3; i++) begin
            integ[i] = 0;
            prev_err[i] = 0;
        end
        directed = '{
            '{'{15'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, -16'sd32768,
                16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b0}},
            '{'{15'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b0}},
            '{'{15'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b1}},
            '{'{15'd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd2000, 16'd2000, 16'd2000, 16'd2000, 1'b1}},
            '{'{15'h7FFF, 16'sd16384, -16'sd16384, 16'sd32767, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{15'd8192, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1, -16'sd32768, 16'sd32767,
                16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{15'd8192, 16'sd0, 16'sd0, -16'sd1, 1'b1, 16'sd16384, -16'sd16384, 16'sd16384,
                16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0},
            '{'{15'd8192, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, -16'sd16384,
                -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0},
            '{'{15'd4000, 16'sd1000, -16'sd2000, 16'sd0, 1'b1, 16'sd100, -16'sd50, 16'sd200,
                16'sd300, -16'sd400, 16'sd10}, 1'b0, '0},
            '{'{15'd4000, 16'sd1000, -16'sd2000, 16'sd0, 1'b1, 16'sd100, -16'sd50, 16'sd200,
                16'sd300, -16'sd400, 16'sd10}, 1'b0, '0},
            '{'{15'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd12345,
                16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b0}},
            '{'{15'd12000, 16'sd500, 16'sd500, 16'sd0, 1'b1, 16'sd0, 16'sd0, 16'sd12000,
                16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{15'h7FFF, 16'sd32767, 16'sd32767, 16'sd0, 1'b1, -16'sd32768, -16'sd32768,
                -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
            '{'{15'd0, -16'sd16384, 16'sd16384, 16'sd0, 1'b1, 16'sd16384, 16'sd16384,
                16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_tick(directed[i].tick, directed[i].typed, directed[i].motors);
        end
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            for (int r = 0; r < qcpm_pkg::NUM_REGS; r++) begin
                case (phase)
                    0: write_gain(qcpm_pkg::reg_idx_t'(r),
                                  qcpm_pkg::REG_RESET[r] >> $urandom_range(0, 3));
                    1: write_gain(qcpm_pkg::reg_idx_t'(r), 32'hFFFF_FFFF);
                    2: write_gain(qcpm_pkg::reg_idx_t'(r), 32'd0);
                    3: write_gain(qcpm_pkg::reg_idx_t'(r), $urandom);
                    default: write_gain(qcpm_pkg::reg_idx_t'(r), qcpm_pkg::REG_RESET[r]);
                endcase
            end
            cfg_valid <= 1'b0;
            armed = 1'b0;
            for (int n = 0; n < 108; n++) begin
                if (phase == 4 && n == 50) begin
                    quiet = 1'b1;
                end
                if (phase == 0 && n == 20) begin
                    hold_req = 1'b1;
                end
                if (phase == 3 && n == 30) begin
                    s_valid <= 1'b0;
                    wait (motor_q.size() == 0);
                    @(posedge aclk);
                end
                if ($urandom_range(0, 9) == 0) begin
                    armed = ~armed;
                end else if (!armed && $urandom_range(0, 1) == 0) begin
                    armed = 1'b1;
                end
                send_tick(rnd_tick(armed), 1'b0, '0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("quad_cascaded_pid_mixer test passed");
        end else begin
            $display("quad_cascaded_pid_mixer test failed");
        end
        $finish;
    end
endmodule
